// ===== rtl/mwvd_pkg.sv =====
// ---------------------------------------------------------------------------
// mwvd_pkg: shared types and constants for the window vote debounce block
// Field widths, register indexes, reset values and payload structs.
// ---------------------------------------------------------------------------
package mwvd_pkg;

    // Fixed field widths
    localparam int PIN_W       = 24;
    localparam int FAULT_W     = 16;
    localparam int TIME_W      = 32;
    localparam int IN_BITS_W   = 16;
    localparam int FB_BITS_W   = 8;
    localparam int THR_W       = 4;
    localparam int QUIET_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_VOTE_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUIET_TICKS    = 2'd1;

    // Register reset values
    localparam logic [THR_W-1:0]   VOTE_THRESHOLD_RST = 4'd6;
    localparam logic [QUIET_W-1:0] QUIET_TICKS_RST    = 16'd100;

    // Parameter defaults
    localparam int NUM_INPUTS_DEF    = 16;
    localparam int NUM_FEEDBACK_DEF  = 8;
    localparam int WINDOW_LENGTH_DEF = 8;

    typedef struct packed {
        logic [PIN_W-1:0]   pin_levels;
        logic [FAULT_W-1:0] channel_faults;
        logic [TIME_W-1:0]  time_now;
    } in_item_t;

    typedef struct packed {
        logic [IN_BITS_W-1:0] input_bits;
        logic [FB_BITS_W-1:0] feedback_bits;
        logic                 inputs_changed;
        logic                 send_event;
    } out_item_t;

endpackage

// ===== rtl/mwvd_lane.sv =====
// ---------------------------------------------------------------------------
// mwvd_lane: one channel's sample window and majority vote
// Stores the sample window and updates the filtered level on each item.
// ---------------------------------------------------------------------------
module mwvd_lane #(
    parameter int WINDOW_LENGTH = mwvd_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             sample_en,
    input  logic [$clog2(WINDOW_LENGTH)-1:0] slot,
    input  logic                             pin_level,
    input  logic [mwvd_pkg::THR_W-1:0]       vote_threshold,
    output logic                             filtered_level
);

    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int CMP_W  = (CNT_W > mwvd_pkg::THR_W) ? CNT_W : mwvd_pkg::THR_W;

    logic [WINDOW_LENGTH-1:0] window_reg;
    logic [WINDOW_LENGTH-1:0] window_next;
    logic                     filt_reg;
    logic                     filt_next;
    logic [CNT_W-1:0]         highs;
    logic [CNT_W-1:0]         lows;
    logic [CMP_W-1:0]         thr_ext;

    always_comb begin
        window_next       = window_reg;
        window_next[slot] = pin_level;
    end

    // popcount of the updated window
    always_comb begin
        highs = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            highs = highs + CNT_W'(window_next[i]);
        end
    end

    assign lows    = CNT_W'(WINDOW_LENGTH) - highs;
    assign thr_ext = CMP_W'(vote_threshold);

    always_comb begin
        filt_next = filt_reg;
        if (CMP_W'(highs) >= thr_ext) begin
            filt_next = 1'b1;
        end else if (CMP_W'(lows) >= thr_ext) begin
            filt_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            filt_reg   <= 1'b0;
        end else if (sample_en) begin
            window_reg <= window_next;
            filt_reg   <= filt_next;
        end
    end

    assign filtered_level = filt_reg;

endmodule

// ===== rtl/mwvd_merge.sv =====
// ---------------------------------------------------------------------------
// mwvd_merge: combines lane levels into the result item
// Applies fault masking, change detection, quiet-time event and output reg.
// ---------------------------------------------------------------------------
module mwvd_merge #(
    parameter int NUM_INPUTS   = mwvd_pkg::NUM_INPUTS_DEF,
    parameter int NUM_FEEDBACK = mwvd_pkg::NUM_FEEDBACK_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 stage_valid,
    input  logic                                 advance,
    input  logic [NUM_INPUTS+NUM_FEEDBACK-1:0]   filt,
    input  logic [mwvd_pkg::FAULT_W-1:0]         faults,
    input  logic [mwvd_pkg::TIME_W-1:0]          time_now,
    input  logic [mwvd_pkg::QUIET_W-1:0]         quiet_ticks,
    output logic                                 m_valid,
    output mwvd_pkg::out_item_t                  m_data
);

    logic [mwvd_pkg::IN_BITS_W-1:0] in_bits;
    logic [mwvd_pkg::FB_BITS_W-1:0] fb_bits;
    logic                           changed;
    logic                           event_hit;
    logic [mwvd_pkg::TIME_W-1:0]    elapsed;

    logic [mwvd_pkg::IN_BITS_W-1:0] prev_bits_reg;
    logic [mwvd_pkg::TIME_W-1:0]    last_change_reg;
    logic                           out_valid_reg;
    mwvd_pkg::out_item_t            out_data_reg;

    for (genvar i = 0; i < mwvd_pkg::IN_BITS_W; i++) begin : g_in
        if (i < NUM_INPUTS && i < mwvd_pkg::FAULT_W) begin : g_fault
            assign in_bits[i] = filt[i] & ~faults[i];
        end else if (i < NUM_INPUTS) begin : g_plain
            assign in_bits[i] = filt[i];
        end else begin : g_none
            assign in_bits[i] = 1'b0;
        end
    end

    for (genvar j = 0; j < mwvd_pkg::FB_BITS_W; j++) begin : g_fb
        if (j < NUM_FEEDBACK) begin : g_used
            assign fb_bits[j] = filt[NUM_INPUTS + j];
        end else begin : g_none
            assign fb_bits[j] = 1'b0;
        end
    end

    assign changed   = (in_bits != prev_bits_reg);
    assign elapsed   = time_now - last_change_reg;
    assign event_hit = changed && (elapsed > mwvd_pkg::TIME_W'(quiet_ticks));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg   <= 1'b0;
            prev_bits_reg   <= '0;
            last_change_reg <= '0;
        end else if (advance) begin
            out_valid_reg <= stage_valid;
            if (stage_valid) begin
                prev_bits_reg <= in_bits;
                if (changed) begin
                    last_change_reg <= time_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stage_valid) begin
            out_data_reg.input_bits     <= in_bits;
            out_data_reg.feedback_bits  <= fb_bits;
            out_data_reg.inputs_changed <= changed;
            out_data_reg.send_event     <= event_hit;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== rtl/multichannel_window_vote_debounce.sv =====
// ---------------------------------------------------------------------------
// multichannel_window_vote_debounce: per-channel window majority debounce
// Filters input and feedback pin levels, masks faults, flags input changes.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries one sample tick per item:
//   raw pin levels, per-input fault flags and the current tick count.
//   Result channel m_valid/m_ready/m_data returns one item per input item:
//   filtered input bits (0 on faulted channels), filtered feedback bits,
//   a change flag and a quiet-time event flag.
//   Configuration: cfg_wr_en/cfg_index/cfg_wdata write vote_threshold
//   (index 0) or quiet_ticks (index 1); other indexes ignored.
// Pipeline:
//   The lanes register window and level when an item is accepted, then the
//   merge stage registers the result item. One item per cycle sustained
//   while m_ready stays high; every channel has its own lane.
// Reset (aresetn low, synchronous): windows, levels, write slot, previous
//   input bits and last change time clear; registers return to 6 and 100.
// Stall: while m_ready is low the result item holds, one more item can sit
//   in the lane stage, then s_ready drops until the result is taken.
// ---------------------------------------------------------------------------
module multichannel_window_vote_debounce #(
    parameter int NUM_INPUTS    = mwvd_pkg::NUM_INPUTS_DEF,
    parameter int NUM_FEEDBACK  = mwvd_pkg::NUM_FEEDBACK_DEF,
    parameter int WINDOW_LENGTH = mwvd_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input items
    input  logic                             s_valid,
    output logic                             s_ready,
    input  mwvd_pkg::in_item_t               s_data,
    // result items
    output logic                             m_valid,
    input  logic                             m_ready,
    output mwvd_pkg::out_item_t              m_data,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [mwvd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwvd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int NUM_CHAN = NUM_INPUTS + NUM_FEEDBACK;
    localparam int SLOT_W   = $clog2(WINDOW_LENGTH);

    // Configuration registers
    logic [mwvd_pkg::THR_W-1:0]   vote_threshold_reg;
    logic [mwvd_pkg::QUIET_W-1:0] quiet_ticks_reg;

    // Handshake and lane-stage control
    logic                          accept;
    logic                          advance;
    logic                          stage_valid_reg;
    logic                          stage_valid_next;
    logic [SLOT_W-1:0]             slot_reg;
    logic [SLOT_W-1:0]             slot_next;
    logic [mwvd_pkg::FAULT_W-1:0]  faults_reg;
    logic [mwvd_pkg::TIME_W-1:0]   time_reg;
    logic [NUM_CHAN-1:0]           filt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_threshold_reg <= mwvd_pkg::VOTE_THRESHOLD_RST;
            quiet_ticks_reg    <= mwvd_pkg::QUIET_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mwvd_pkg::REG_VOTE_THRESHOLD: begin
                    vote_threshold_reg <= cfg_wdata[mwvd_pkg::THR_W-1:0];
                end
                mwvd_pkg::REG_QUIET_TICKS: begin
                    quiet_ticks_reg <= cfg_wdata[mwvd_pkg::QUIET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Lane stage moves on when the output register is free or being drained.
    assign advance = !m_valid || m_ready;
    assign s_ready = !stage_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
    end

    // Slot advances before the write, so the first sample lands in slot 1.
    assign slot_next = (slot_reg == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            slot_reg        <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            if (accept) begin
                slot_reg <= slot_next;
            end
        end
    end

    // Fault flags and time ride along with the lane stage.
    always_ff @(posedge aclk) begin
        if (accept) begin
            faults_reg <= s_data.channel_faults;
            time_reg   <= s_data.time_now;
        end
    end

    // One lane per channel; channels past the pin field sample low.
    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        logic lane_pin;
        if (c < mwvd_pkg::PIN_W) begin : g_pin
            assign lane_pin = s_data.pin_levels[c];
        end else begin : g_nopin
            assign lane_pin = 1'b0;
        end

        mwvd_lane #(
            .WINDOW_LENGTH (WINDOW_LENGTH)
        ) u_lane (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .sample_en      (accept),
            .slot           (slot_next),
            .pin_level      (lane_pin),
            .vote_threshold (vote_threshold_reg),
            .filtered_level (filt[c])
        );
    end

    // Merge stage: masking, change detection, event and result register.
    mwvd_merge #(
        .NUM_INPUTS   (NUM_INPUTS),
        .NUM_FEEDBACK (NUM_FEEDBACK)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage_valid (stage_valid_reg),
        .advance     (advance),
        .filt        (filt),
        .faults      (faults_reg),
        .time_now    (time_reg),
        .quiet_ticks (quiet_ticks_reg),
        .m_valid     (m_valid),
        .m_data      (m_data)
    );

endmodule
